// ===== rtl/core/bmffus_pkg.sv =====
// bmffus_pkg: shared types, widths and constants of the uuid box scanner
// no dependencies; imported by the channel interfaces, the walker and the top level
package bmffus_pkg;

  // default offset width and fixed field widths
  localparam int OFFSET_WIDTH_DEF = 48;
  localparam int FILE_LEN_W       = 48;
  localparam int BOX_LEN_W        = 64;
  localparam int KIND_W           = 32;
  localparam int DATA_W           = 8;
  localparam int HCNT_W           = 5;
  localparam int VERDICT_W        = 2;

  // box header geometry
  localparam int HDR_SHORT = 8;
  localparam int HDR_LONG  = 16;
  localparam int ID_BYTES  = 16;

  // box type 'uuid'
  localparam logic [KIND_W-1:0] KIND_UUID = 32'h7575_6964;

  // manifest id, first byte at index zero
  localparam logic [DATA_W-1:0] MANIFEST_ID [ID_BYTES] = '{
    8'hD8, 8'hFE, 8'hC3, 8'hD6, 8'h1B, 8'h0E, 8'h48, 8'h3C,
    8'h92, 8'h97, 8'h58, 8'h28, 8'h87, 8'h7E, 8'hC4, 8'h81
  };

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_SCANNING  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FOUND     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_FOUND = 2'd2;

  // walk phases
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ID     = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // one registered input beat handed to the walker
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              start_of_file;
  } walk_beat_t;

endpackage

// ===== rtl/core/bmffus_ifs.sv =====
// bmffus_ifs: valid/ready channel interfaces for file bytes and verdicts
// depends on bmffus_pkg for payload widths
interface bmffus_in_if import bmffus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface bmffus_out_if import bmffus_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// ===== rtl/core/bmffus_walker.sv =====
// bmffus_walker: box walk state and the per-byte update of that state
// depends on bmffus_pkg; instantiated by bmff_uuid_box_scanner
module bmffus_walker import bmffus_pkg::*; #(
  parameter int OFS_W = OFFSET_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  walk_beat_t            beat,
  input  logic [FILE_LEN_W-1:0] file_length,
  output logic [VERDICT_W-1:0]  verdict
);

  logic [OFS_W-1:0]     byte_offset_r, byte_offset_nxt;
  logic [OFS_W-1:0]     box_origin_r, box_origin_nxt;
  logic [BOX_LEN_W-1:0] box_length_r, box_length_nxt;
  logic [KIND_W-1:0]    box_kind_r, box_kind_nxt;
  logic [HCNT_W-1:0]    header_count_r, header_count_nxt;
  logic                 id_match_r, id_match_nxt;
  phase_t               phase_r, phase_nxt;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;

  // state seen by this beat: a start of file restarts the walk first
  logic [OFS_W-1:0]     cur_ofs, cur_origin;
  logic [BOX_LEN_W-1:0] cur_len;
  logic [KIND_W-1:0]    cur_kind;
  logic [HCNT_W-1:0]    cur_hc;
  logic                 cur_idm;
  phase_t               cur_phase;
  logic [VERDICT_W-1:0] cur_verdict;

  always_comb begin
    if (beat.start_of_file) begin
      cur_ofs     = '0;
      cur_origin  = '0;
      cur_len     = '0;
      cur_kind    = '0;
      cur_hc      = '0;
      cur_idm     = 1'b1;
      cur_phase   = PH_HEADER;
      cur_verdict = VERDICT_SCANNING;
    end else begin
      cur_ofs     = byte_offset_r;
      cur_origin  = box_origin_r;
      cur_len     = box_length_r;
      cur_kind    = box_kind_r;
      cur_hc      = header_count_r;
      cur_idm     = id_match_r;
      cur_phase   = phase_r;
      cur_verdict = verdict_r;
    end
  end

  // remaining length from the box start and from the byte after this one
  logic [OFS_W-1:0]     file_end, ofs_inc, rem, nb_rem, last_ofs;
  logic [BOX_LEN_W-1:0] rem64;
  logic                 hit_last, nb_short;

  assign file_end = OFS_W'(file_length);
  assign ofs_inc  = cur_ofs + OFS_W'(1);
  assign rem      = (file_end > cur_origin) ? (file_end - cur_origin) : '0;
  assign rem64    = BOX_LEN_W'(rem);
  assign nb_rem   = (file_end > ofs_inc) ? (file_end - ofs_inc) : '0;
  assign nb_short = (nb_rem < OFS_W'(HDR_SHORT));
  assign last_ofs = cur_origin + cur_len[OFS_W-1:0] - OFS_W'(1);
  assign hit_last = (cur_ofs == last_ofs);

  // next state: header collection, id compare, body skip
  logic [BOX_LEN_W-1:0] len_shift, hdr_len, hdr_size, id_min;
  logic [KIND_W-1:0]    kind_shift, hdr_kind;
  logic                 hdr_end, hdr_long, go_next, id_hit;
  logic [3:0]           id_idx;

  always_comb begin
    len_shift  = {cur_len[BOX_LEN_W-DATA_W-1:0], beat.data_byte};
    kind_shift = {cur_kind[KIND_W-DATA_W-1:0], beat.data_byte};
    hdr_end    = 1'b0;
    hdr_long   = (cur_hc == HCNT_W'(HDR_LONG - 1));
    hdr_len    = hdr_long ? len_shift
               : ((cur_len == '0) ? rem64 : cur_len);
    hdr_kind   = hdr_long ? cur_kind : kind_shift;
    hdr_size   = hdr_long ? BOX_LEN_W'(HDR_LONG) : BOX_LEN_W'(HDR_SHORT);
    id_min     = hdr_long ? BOX_LEN_W'(HDR_LONG + ID_BYTES)
               : BOX_LEN_W'(HDR_SHORT + ID_BYTES);
    id_idx     = cur_hc[3:0];
    id_hit     = cur_idm && (beat.data_byte == MANIFEST_ID[id_idx]);
    go_next    = 1'b0;

    byte_offset_nxt  = ofs_inc;
    box_origin_nxt   = cur_origin;
    box_length_nxt   = cur_len;
    box_kind_nxt     = cur_kind;
    header_count_nxt = cur_hc;
    id_match_nxt     = cur_idm;
    phase_nxt        = cur_phase;
    verdict_nxt      = cur_verdict;

    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_hc == '0 && rem < OFS_W'(HDR_SHORT)) begin
          phase_nxt   = PH_DONE;
          verdict_nxt = VERDICT_NOT_FOUND;
        end else begin
          header_count_nxt = cur_hc + HCNT_W'(1);
          if (cur_hc < HCNT_W'(4)) begin
            box_length_nxt = len_shift;
          end else if (cur_hc < HCNT_W'(HDR_SHORT)) begin
            box_kind_nxt = kind_shift;
          end else if (cur_hc == HCNT_W'(HDR_SHORT)) begin
            box_length_nxt = BOX_LEN_W'(beat.data_byte);
          end else begin
            box_length_nxt = len_shift;
          end
          // end of the short header: size 1 asks for a 64-bit size
          if (cur_hc == HCNT_W'(HDR_SHORT - 1)) begin
            if (cur_len == BOX_LEN_W'(1)) begin
              if (rem < OFS_W'(HDR_LONG)) begin
                phase_nxt   = PH_DONE;
                verdict_nxt = VERDICT_NOT_FOUND;
              end
            end else begin
              hdr_end = 1'b1;
            end
          end else if (hdr_long) begin
            hdr_end = 1'b1;
          end
          // header complete: check size, then id or skip
          if (hdr_end) begin
            box_length_nxt = hdr_len;
            if (hdr_len < hdr_size || hdr_len > rem64) begin
              phase_nxt   = PH_DONE;
              verdict_nxt = VERDICT_NOT_FOUND;
            end else if (hdr_kind == KIND_UUID && hdr_len >= id_min) begin
              phase_nxt        = PH_ID;
              header_count_nxt = '0;
              id_match_nxt     = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
              go_next   = (hdr_len == hdr_size);
            end
          end
        end
      end
      PH_ID: begin
        id_match_nxt     = id_hit;
        header_count_nxt = cur_hc + HCNT_W'(1);
        if (id_idx == 4'(ID_BYTES - 1)) begin
          if (id_hit) begin
            phase_nxt   = PH_DONE;
            verdict_nxt = VERDICT_FOUND;
          end else begin
            phase_nxt = PH_SKIP;
            go_next   = hit_last;
          end
        end
      end
      PH_SKIP: begin
        go_next = hit_last;
      end
      PH_DONE: begin
        go_next = 1'b0;
      end
      default: begin
        go_next = 1'b0;
      end
    endcase

    // last byte of a box: open the next one right after it
    if (go_next) begin
      box_origin_nxt   = ofs_inc;
      box_length_nxt   = '0;
      box_kind_nxt     = '0;
      header_count_nxt = '0;
      id_match_nxt     = 1'b1;
      phase_nxt        = PH_HEADER;
      if (nb_short) begin
        phase_nxt   = PH_DONE;
        verdict_nxt = VERDICT_NOT_FOUND;
      end
    end
  end

  // state registers, updated once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r  <= '0;
      box_origin_r   <= '0;
      box_length_r   <= '0;
      box_kind_r     <= '0;
      header_count_r <= '0;
      id_match_r     <= 1'b1;
      phase_r        <= PH_HEADER;
      verdict_r      <= VERDICT_SCANNING;
    end else if (step_en) begin
      byte_offset_r  <= byte_offset_nxt;
      box_origin_r   <= box_origin_nxt;
      box_length_r   <= box_length_nxt;
      box_kind_r     <= box_kind_nxt;
      header_count_r <= header_count_nxt;
      id_match_r     <= id_match_nxt;
      phase_r        <= phase_nxt;
      verdict_r      <= verdict_nxt;
    end
  end

  // output: verdict after the latest beat
  assign verdict = verdict_r;

endmodule

// ===== rtl/core/bmff_uuid_box_scanner.sv =====
// bmff_uuid_box_scanner: top level of the iso bmff uuid box scanner
// depends on bmffus_pkg, bmffus_ifs and bmffus_walker
//
// usage:
//   in_bus carries the file one byte per beat in file order; start_of_file
//   marks the byte at offset zero and restarts the scan.
//   out_bus returns exactly one verdict per input beat: scanning, manifest
//   uuid found, or not found. found and not found are final and repeat on
//   every later beat until the next start_of_file.
//   cfg_wr_en/cfg_wr_data write the file length; write it while no beat is
//   in flight.
// timing:
//   one byte per cycle sustained while out_bus.ready stays high; each verdict
//   is registered in the walker state register, fed by the input register.
// reset:
//   synchronous active-low rst_n empties both stages, clears the file
//   length and starts a scan at offset zero.
// stalls:
//   while out_bus.ready is low the verdict holds; one more byte waits in
//   the input register, after which in_bus.ready drops.
module bmff_uuid_box_scanner import bmffus_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmffus_in_if.sink             in_bus,
  bmffus_out_if.source          out_bus,
  input  logic                  cfg_wr_en,
  input  logic [FILE_LEN_W-1:0] cfg_wr_data
);

  logic [FILE_LEN_W-1:0] file_length_r;
  walk_beat_t            beat_r;
  logic                  beat_valid_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  step_en;

  // file length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else if (cfg_wr_en) begin
      file_length_r <= cfg_wr_data;
    end
  end

  // pipeline flow: the walker steps when the result slot is free or taken
  assign advance      = !out_valid_r || out_bus.ready;
  assign step_en      = beat_valid_r && advance;
  assign in_bus.ready = !beat_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      beat_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      beat_r.data_byte     <= in_bus.data_byte;
      beat_r.start_of_file <= in_bus.start_of_file;
    end
  end

  // result valid; the verdict itself lives in the walker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= beat_valid_r;
    end
  end

  bmffus_walker #(
    .OFS_W (OFFSET_WIDTH)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .beat        (beat_r),
    .file_length (file_length_r),
    .verdict     (out_bus.verdict)
  );

  assign out_bus.valid = out_valid_r;

endmodule

// ===== tb/tb_bmff_uuid_box_scanner.sv =====
// tb_bmff_uuid_box_scanner: self-checking bench for the iso bmff uuid box scanner
// feeds directed and random box streams, predicts each verdict with a software walk
// depends on bmffus_pkg, bmffus_ifs and the bmff_uuid_box_scanner rtl
module tb_bmff_uuid_box_scanner;
  import bmffus_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int WALK_TARGET = 1030;
  localparam logic [31:0] UUID_TYPE = 32'h7575_6964;
  localparam logic [7:0] MANIFEST_BYTES [16] = '{
    8'hD8, 8'hFE, 8'hC3, 8'hD6, 8'h1B, 8'h0E, 8'h48, 8'h3C,
    8'h92, 8'h97, 8'h58, 8'h28, 8'h87, 8'h7E, 8'hC4, 8'h81
  };

  // one directed row: optional length write, then one byte beat
  typedef struct packed {
    logic                  set_len;
    logic [FILE_LEN_W-1:0] len;
    logic [DATA_W-1:0]     data;
    logic                  sof;
    logic                  pinned;
    logic [VERDICT_W-1:0]  want;
  } probe_t;

  typedef struct packed {
    logic                 pinned;
    logic [VERDICT_W-1:0] want;
  } pinned_verdict_t;

  localparam probe_t PROBES [26] = '{
    // after reset, no start marker, zero length: gives up at once and repeats
    '{1'b0, 48'd0, 8'h00, 1'b0, 1'b1, VERDICT_NOT_FOUND},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b1, VERDICT_NOT_FOUND},
    // one 8-byte free box filling the file: answer comes on its last byte
    '{1'b1, 48'd8, 8'h00, 1'b1, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h00, 1'b0, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h00, 1'b0, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h08, 1'b0, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h66, 1'b0, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h72, 1'b0, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h65, 1'b0, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h65, 1'b0, 1'b1, VERDICT_NOT_FOUND},
    // largest length, long header with 64-bit size all ones: too big for the file
    '{1'b1, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b1, 1'b1, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h00, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h00, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h01, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h75, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h75, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h69, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'h64, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b0, VERDICT_SCANNING},
    '{1'b0, 48'd0, 8'hFF, 1'b0, 1'b1, VERDICT_NOT_FOUND}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [FILE_LEN_W-1:0] cfg_wr_data;

  bmffus_in_if  in_bus ();
  bmffus_out_if out_bus ();

  bmff_uuid_box_scanner dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predicted walk state
  logic [47:0]          file_len;
  logic [47:0]          next_pos;
  logic [47:0]          box_start;
  logic [63:0]          box_size;
  logic [31:0]          box_type;
  logic [4:0]           hdr_seen;
  logic                 id_ok;
  phase_t               walk_ph;
  logic [VERDICT_W-1:0] walk_verdict;

  // expected verdicts in beat order, and pinned values from the directed table
  logic [VERDICT_W-1:0] due_verdicts [$];
  pinned_verdict_t      pinned_verdicts [$];
  logic [7:0]           file_img [$];

  int  beats_sent;
  int  beats_fed;
  int  results_seen;
  int  bytes_walked;
  int  hits;
  int  misses;
  int  errors;
  int  quiet;
  int  files_walked;
  int  length_writes;
  bit  steady_feed;

  function automatic logic [63:0] bytes_left();
    return (file_len > box_start) ? 64'(file_len - box_start) : 64'd0;
  endfunction

  function automatic void abandon();
    walk_verdict = VERDICT_NOT_FOUND;
    walk_ph      = PH_DONE;
  endfunction

  function automatic void rewind();
    next_pos     = '0;
    box_start    = '0;
    box_size     = '0;
    box_type     = '0;
    hdr_seen     = '0;
    id_ok        = 1'b1;
    walk_ph      = PH_HEADER;
    walk_verdict = VERDICT_SCANNING;
  endfunction

  function automatic void advance_box();
    box_start = 48'(64'(box_start) + box_size);
    box_size  = '0;
    box_type  = '0;
    hdr_seen  = '0;
    id_ok     = 1'b1;
    walk_ph   = PH_HEADER;
    if (bytes_left() < 64'd8) abandon();
  endfunction

  // move on once the byte at ofs is the last one of the current box
  function automatic void check_box_end(input logic [47:0] ofs);
    logic [47:0] last_ofs;
    last_ofs = 48'(64'(box_start) + box_size - 64'd1);
    if (ofs == last_ofs) advance_box();
  endfunction

  function automatic void header_complete(input int unsigned hdr, input logic [47:0] ofs);
    logic [63:0] rem;
    rem = bytes_left();
    if (box_size < 64'(hdr) || box_size > rem) begin
      abandon();
      return;
    end
    if (box_type == UUID_TYPE && box_size >= 64'(hdr + 16)) begin
      walk_ph  = PH_ID;
      hdr_seen = '0;
      id_ok    = 1'b1;
      return;
    end
    walk_ph = PH_SKIP;
    check_box_end(ofs);
  endfunction

  function automatic void walk_byte(input logic [7:0] b, input logic [47:0] ofs);
    int unsigned n;
    case (walk_ph)
      PH_HEADER: begin
        n = 32'(hdr_seen);
        if (n == 0 && bytes_left() < 64'd8) begin
          abandon();
          return;
        end
        if (n < 4 || n > 8) box_size = {box_size[55:0], b};
        else if (n < 8) box_type = {box_type[23:0], b};
        else box_size = 64'(b);
        hdr_seen = hdr_seen + 5'd1;
        if (n == 7) begin
          // size 1 means a 64-bit size follows, size 0 runs to the end of file
          if (box_size == 64'd1) begin
            if (bytes_left() < 64'd16) abandon();
          end else begin
            if (box_size == 64'd0) box_size = bytes_left();
            header_complete(8, ofs);
          end
        end else if (n == 15) begin
          header_complete(16, ofs);
        end
      end
      PH_ID: begin
        n = 32'(hdr_seen[3:0]);
        if (b != MANIFEST_BYTES[hdr_seen[3:0]]) id_ok = 1'b0;
        hdr_seen = hdr_seen + 5'd1;
        if (n == 15) begin
          if (id_ok) begin
            walk_verdict = VERDICT_FOUND;
            walk_ph      = PH_DONE;
          end else begin
            walk_ph = PH_SKIP;
            check_box_end(ofs);
          end
        end
      end
      PH_SKIP: check_box_end(ofs);
      default: ;
    endcase
  endfunction

  function automatic logic [VERDICT_W-1:0] predict_verdict(input logic [7:0] b, input logic sof);
    logic [47:0] ofs;
    if (sof) rewind();
    ofs = next_pos;
    if (walk_verdict == VERDICT_SCANNING) walk_byte(b, ofs);
    next_pos = ofs + 48'd1;
    return walk_verdict;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_word(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) file_img.push_back(v[8*i +: 8]);
  endfunction

  // build a short file of random boxes, most of them well formed
  function automatic void compose_file();
    int          nbox;
    int          body;
    int          flip;
    int unsigned pick;
    bit          with_id;
    bit          to_end;
    logic [31:0] tag;
    file_img.delete();
    nbox = $urandom_range(1, 4);
    for (int k = 0; k < nbox; k++) begin
      pick    = $urandom_range(0, 11);
      body    = $urandom_range(0, 10);
      tag     = $urandom();
      with_id = 1'b0;
      to_end  = 1'b0;
      flip    = -1;
      case (pick)
        4, 5: begin
          put_word(64'(24 + body), 4);
          put_word(64'(UUID_TYPE), 4);
          with_id = 1'b1;
        end
        6: begin
          put_word(64'(24 + body), 4);
          put_word(64'(UUID_TYPE), 4);
          with_id = 1'b1;
          flip    = $urandom_range(0, 15);
        end
        7: begin
          with_id = 1'($urandom_range(0, 1));
          if (with_id) tag = UUID_TYPE;
          put_word(64'd1, 4);
          put_word(64'(tag), 4);
          put_word(64'(16 + (with_id ? 16 : 0) + body), 8);
        end
        8: begin
          body = $urandom_range(0, 15);
          put_word(64'(8 + body), 4);
          put_word(64'(UUID_TYPE), 4);
        end
        9: begin
          with_id = 1'($urandom_range(0, 1));
          if (with_id) tag = UUID_TYPE;
          put_word(64'd0, 4);
          put_word(64'(tag), 4);
          to_end = 1'b1;
        end
        10: begin
          put_word(64'($urandom_range(2, 7)), 4);
          put_word(64'(tag), 4);
        end
        11: begin
          put_word(64'($urandom() | 32'h0100_0000), 4);
          put_word(64'(tag), 4);
        end
        default: begin
          put_word(64'(8 + body), 4);
          put_word(64'(tag), 4);
        end
      endcase
      if (with_id) begin
        for (int i = 0; i < 16; i++)
          file_img.push_back(MANIFEST_BYTES[4'(i)] ^
                             ((i == flip) ? 8'(1 << $urandom_range(0, 7)) : 8'h00));
      end
      for (int i = 0; i < body; i++) file_img.push_back(8'($urandom()));
      if (to_end) break;
    end
  endfunction

  // mostly the true size, sometimes short, long or an extreme
  function automatic logic [47:0] pick_length(input int unsigned size);
    case ($urandom_range(0, 9))
      7: return 48'(size - $urandom_range(0, size));
      8: return 48'(size + $urandom_range(1, 20));
      9: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return 48'({$urandom(), $urandom()});
        endcase
      end
      default: return 48'(size);
    endcase
  endfunction

  // drain everything in flight, then write the file length
  task automatic set_file_length(input logic [47:0] len);
    in_bus.valid <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    file_len     = len;
    length_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one byte beat; valid stays high when the next beat follows without a gap
  task automatic send_beat(input logic [7:0] b, input logic sof, input logic pinned,
                           input logic [VERDICT_W-1:0] want);
    pinned_verdict_t pv;
    int unsigned     gap;
    pv.pinned = pinned;
    pv.want   = want;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_verdicts.push_back(pv);
    beats_sent++;
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.start_of_file <= sof;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side back-pressure
  initial begin : sink_pacing
    int unsigned stall;
    out_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // accepted beats: predict on the input side, compare on the result side
  always @(posedge clk) begin : beat_watch
    pinned_verdict_t      pv;
    logic [VERDICT_W-1:0] predicted;
    logic [VERDICT_W-1:0] want;
    bit                   open;
    bit                   in_fire;
    bit                   out_fire;
    if (rst_n) begin
      in_fire  = in_bus.valid && in_bus.ready;
      out_fire = out_bus.valid && out_bus.ready;
      if (in_fire) begin
        open      = in_bus.start_of_file || walk_verdict == VERDICT_SCANNING;
        predicted = predict_verdict(in_bus.data_byte, in_bus.start_of_file);
        pv.pinned = 1'b0;
        pv.want   = VERDICT_SCANNING;
        if (pinned_verdicts.size() != 0) pv = pinned_verdicts.pop_front();
        due_verdicts.push_back(pv.pinned ? pv.want : predicted);
        beats_fed++;
        if (open) begin
          bytes_walked++;
          if (predicted == VERDICT_FOUND) hits++;
          else if (predicted == VERDICT_NOT_FOUND) misses++;
        end
      end
      if (out_fire) begin
        results_seen++;
        if (due_verdicts.size() == 0) begin
          errors++;
          $display("%0t: verdict %0d with nothing expected", $time, out_bus.verdict);
        end else begin
          want = due_verdicts.pop_front();
          if (out_bus.verdict !== want) begin
            errors++;
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, want, out_bus.verdict);
          end
        end
      end
      // watchdog on cycles with no beat moving
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_bmff_uuid_box_scanner NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned size;
    int          split_at;
    int          resync_at;
    probe_t      row;
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = '0;
    in_bus.start_of_file = 1'b0;
    steady_feed          = 1'b0;
    file_len             = '0;
    rewind();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (PROBES[i]) begin
      row = PROBES[i];
      if (row.set_len) set_file_length(row.len);
      send_beat(row.data, row.sof, row.pinned, row.want);
    end

    // random files until enough beats have been sent
    while (beats_sent < WALK_TARGET) begin
      files_walked++;
      if ($urandom_range(0, 9) == 0) begin
        file_img.delete();
        repeat ($urandom_range(8, 40)) file_img.push_back(8'($urandom()));
      end else begin
        compose_file();
      end
      size = file_img.size();
      set_file_length(pick_length(size));
      if ($urandom_range(0, 7) == 0) begin
        split_at = $urandom_range(1, file_img.size());
        while (file_img.size() > split_at) void'(file_img.pop_back());
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 12)) file_img.push_back(8'($urandom()));
      split_at  = (file_img.size() > 2 && $urandom_range(0, 5) == 0) ?
                  $urandom_range(1, file_img.size() - 1) : -1;
      resync_at = (file_img.size() > 2 && $urandom_range(0, 11) == 0) ?
                  $urandom_range(1, file_img.size() - 1) : -1;
      steady_feed = ($urandom_range(0, 3) == 0);
      foreach (file_img[i]) begin
        // length rewritten partway through a file
        if (i == split_at) set_file_length(pick_length(size));
        send_beat(file_img[i], i == 0 || i == resync_at, 1'b0, VERDICT_SCANNING);
      end
    end

    // drain and settle
    in_bus.valid <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_verdicts.size() != 0) begin
      errors++;
      $display("%0t: %0d verdicts never arrived", $time, due_verdicts.size());
    end

    $display("walked %0d file bytes (%0d beats) over %0d files with %0d length writes",
             bytes_walked, beats_fed, files_walked, length_writes);
    $display("scans ended: %0d manifest found, %0d not found; %0d mismatches",
             hits, misses, errors);
    if (errors == 0) begin
      $display("tb_bmff_uuid_box_scanner OK");
    end else begin
      $display("tb_bmff_uuid_box_scanner NOT OK");
    end
    $finish;
  end

endmodule

// ===== bmff_uuid_box_scanner.f =====
rtl/core/bmffus_pkg.sv
rtl/core/bmffus_ifs.sv
rtl/core/bmffus_walker.sv
rtl/core/bmff_uuid_box_scanner.sv
tb/tb_bmff_uuid_box_scanner.sv
